// ===== rtl/ternary_weight_fp16_dot_accumulator_assert.svh =====
// assertion macros used by the checker module
`ifndef TERNARY_WEIGHT_FP16_DOT_ACCUMULATOR_ASSERT_SVH
`define TERNARY_WEIGHT_FP16_DOT_ACCUMULATOR_ASSERT_SVH

// condition in one cycle implies consequence in the next
`define TWFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("twfd check failed: next-cycle rule");

// condition implies consequence in the same cycle
`define TWFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("twfd check failed: same-cycle rule");

`endif

// ===== rtl/twfd_pkg.sv =====
package twfd_pkg;

    localparam int LANES     = 4;
    localparam int LANE_W    = $clog2(LANES);
    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_PZERO = 32'h0000_0000;

    // 2-bit weight codes
    typedef enum logic [1:0] {
        W_NEG  = 2'd0,
        W_ZERO = 2'd1,
        W_POS  = 2'd2,
        W_TWO  = 2'd3
    } t_wcode;

    // exact fp16 to fp32 widening, subnormals normalized
    function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] m;
        logic [3:0] lz;
        logic       found;
        logic [3:0] sh;
        logic [9:0] mn;
        logic [7:0] e8;
        logic [31:0] r;
        s     = h[15];
        ex    = h[14:10];
        m     = h[9:0];
        lz    = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found) begin
                if (m[i]) begin
                    found = 1'b1;
                end else begin
                    lz = lz + 4'd1;
                end
            end
        end
        sh = lz + 4'd1;
        mn = m << sh;
        e8 = 8'd113 - {4'b0, sh};
        if (ex == 5'd0) begin
            if (m == 10'd0) begin
                r = {s, 31'b0};
            end else begin
                r = {s, e8, mn, 13'b0};
            end
        end else if (ex == 5'h1F) begin
            r = {s, 8'hFF, m, 13'b0};
        end else begin
            r = {s, {3'b0, ex} + 8'd112, m, 13'b0};
        end
        return r;
    endfunction

    // truncating fp32 to fp16 narrowing, tiny values flush to signed zero
    function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
        logic        s;
        logic [7:0]  ex;
        logic [22:0] m;
        logic [4:0]  shamt;
        logic [23:0] full;
        logic [7:0]  eh;
        logic [15:0] r;
        s     = x[31];
        ex    = x[30:23];
        m     = x[22:0];
        shamt = 5'(8'd126 - ex);
        full  = {1'b1, m} >> shamt;
        eh    = ex - 8'd112;
        if (ex == 8'hFF) begin
            r = {s, 5'h1F, (m != 23'd0) ? 10'h200 : 10'h000};
        end else if (ex > 8'd142) begin
            r = {s, 5'h1F, 10'h000};
        end else if (ex < 8'd113) begin
            if (ex < 8'd103) begin
                r = {s, 15'b0};
            end else begin
                r = {s, 5'b0, full[9:0]};
            end
        end else begin
            r = {s, eh[4:0], m[22:13]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/twfd_lane.sv =====
module twfd_lane (
    input  logic [1:0]  i_code,
    input  logic [15:0] i_act,
    input  logic [15:0] i_scale,
    output logic [31:0] o_prod
);
    import twfd_pkg::*;

    logic [31:0] w_sc;
    logic [31:0] w_act;
    logic [31:0] w_wt;
    logic        sc_nan, sc_inf, sc_zero;
    logic        wt_nan, wt_inf, wt_zero;
    logic        ac_nan, ac_inf, ac_zero;
    logic        psign;
    logic [21:0] mprod;
    logic [9:0]  pexp;
    logic [22:0] pman;

    assign w_sc  = f16_to_f32(i_scale);
    assign w_act = f16_to_f32(i_act);

    assign sc_nan  = (w_sc[30:23] == 8'hFF) && (w_sc[22:0] != 23'd0);
    assign sc_inf  = (w_sc[30:23] == 8'hFF) && (w_sc[22:0] == 23'd0);
    assign sc_zero = (w_sc[30:0] == 31'd0);

    // weight = (code - 1) * scale, already exact in fp16 except overflow at x2
    always_comb begin
        case (t_wcode'(i_code))
            W_NEG:  w_wt = {~w_sc[31], w_sc[30:0]};
            W_ZERO: w_wt = sc_inf ? F32_QNAN : {w_sc[31], 31'b0};
            W_POS:  w_wt = w_sc;
            W_TWO: begin
                if (sc_inf || sc_zero) begin
                    w_wt = w_sc;
                end else if (w_sc[30:23] == 8'd142) begin
                    w_wt = {w_sc[31], 8'hFF, 23'b0};
                end else begin
                    w_wt = {w_sc[31], w_sc[30:23] + 8'd1, w_sc[22:0]};
                end
            end
            default: w_wt = F32_QNAN;
        endcase
        if (sc_nan) begin
            w_wt = F32_QNAN;
        end
    end

    assign wt_nan  = (w_wt[30:23] == 8'hFF) && (w_wt[22:0] != 23'd0);
    assign wt_inf  = (w_wt[30:23] == 8'hFF) && (w_wt[22:0] == 23'd0);
    assign wt_zero = (w_wt[30:0] == 31'd0);
    assign ac_nan  = (w_act[30:23] == 8'hFF) && (w_act[22:0] != 23'd0);
    assign ac_inf  = (w_act[30:23] == 8'hFF) && (w_act[22:0] == 23'd0);
    assign ac_zero = (w_act[30:0] == 31'd0);
    assign psign   = w_wt[31] ^ w_act[31];

    // 11x11 significand product, always exact in fp32
    assign mprod = {1'b1, w_wt[22:13]} * {1'b1, w_act[22:13]};
    assign pexp  = {2'b0, w_wt[30:23]} + {2'b0, w_act[30:23]} - 10'd127
                   + {9'b0, mprod[21]};
    assign pman  = mprod[21] ? {mprod[20:0], 2'b0} : {mprod[19:0], 3'b0};

    always_comb begin
        if (wt_nan || ac_nan || (wt_inf && ac_zero) || (wt_zero && ac_inf)) begin
            o_prod = F32_QNAN;
        end else if (wt_inf || ac_inf) begin
            o_prod = {psign, 8'hFF, 23'b0};
        end else if (wt_zero || ac_zero) begin
            o_prod = {psign, 31'b0};
        end else begin
            o_prod = {psign, pexp[7:0], pman};
        end
    end

endmodule

// ===== rtl/twfd_fadd.sv =====
module twfd_fadd (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_sum
);
    import twfd_pkg::*;

    logic        a_nan, a_inf, a_zero;
    logic        b_nan, b_inf, b_zero;
    logic        a_ge;
    logic [31:0] x, y;
    logic [7:0]  d;
    logic [4:0]  dcap;
    logic [56:0] wide;
    logic [26:0] ax, by;
    logic [27:0] s28;
    logic [4:0]  lz;
    logic        found;
    logic [26:0] m27;
    logic [9:0]  e10;
    logic        rnd;
    logic [24:0] m25;
    logic [9:0]  ef;
    logic [22:0] mf;
    logic [31:0] w_gen;

    assign a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
    assign a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
    assign a_zero = (i_a[30:23] == 8'd0);
    assign b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
    assign b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
    assign b_zero = (i_b[30:23] == 8'd0);

    // larger magnitude first
    assign a_ge = (i_a[30:0] >= i_b[30:0]);
    assign x    = a_ge ? i_a : i_b;
    assign y    = a_ge ? i_b : i_a;
    assign d    = x[30:23] - y[30:23];
    assign dcap = (d > 8'd31) ? 5'd31 : d[4:0];

    // align with guard, round and sticky
    assign wide = {1'b1, y[22:0], 33'b0} >> dcap;
    assign by   = {wide[56:31], |wide[30:0]};
    assign ax   = {1'b1, x[22:0], 3'b0};
    assign s28  = (x[31] ^ y[31]) ? ({1'b0, ax} - {1'b0, by})
                                  : ({1'b0, ax} + {1'b0, by});

    always_comb begin
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found) begin
                if (s28[i]) begin
                    found = 1'b1;
                end else begin
                    lz = lz + 5'd1;
                end
            end
        end
    end

    always_comb begin
        if (s28[27]) begin
            m27 = {s28[27:2], s28[1] | s28[0]};
            e10 = {2'b0, x[30:23]} + 10'd1;
        end else begin
            m27 = s28[26:0] << lz;
            e10 = {2'b0, x[30:23]} - {5'b0, lz};
        end
        // round to nearest even
        rnd = m27[2] & (m27[1] | m27[0] | m27[3]);
        m25 = {1'b0, m27[26:3]} + {24'b0, rnd};
        if (m25[24]) begin
            ef = e10 + 10'd1;
            mf = 23'd0;
        end else begin
            ef = e10;
            mf = m25[22:0];
        end
        if (s28 == 28'd0) begin
            w_gen = F32_PZERO;
        end else if (ef[9] || ef == 10'd0) begin
            w_gen = {x[31], 31'b0};
        end else if (ef >= 10'd255) begin
            w_gen = {x[31], 8'hFF, 23'b0};
        end else begin
            w_gen = {x[31], ef[7:0], mf};
        end
    end

    always_comb begin
        if (a_nan || b_nan) begin
            o_sum = F32_QNAN;
        end else if (a_inf && b_inf) begin
            o_sum = (i_a[31] != i_b[31]) ? F32_QNAN : i_a;
        end else if (a_inf) begin
            o_sum = i_a;
        end else if (b_inf) begin
            o_sum = i_b;
        end else if (a_zero && b_zero) begin
            o_sum = {i_a[31] & i_b[31], 31'b0};
        end else if (a_zero) begin
            o_sum = i_b;
        end else if (b_zero) begin
            o_sum = i_a;
        end else begin
            o_sum = w_gen;
        end
    end

endmodule

// ===== rtl/ternary_weight_fp16_dot_accumulator.sv =====
// channel | direction | handshake           | payload
// input   | in        | i_valid / o_stall   | i_code_byte, i_act_lane0..3, i_block_scale,
//         |           |                     | i_last_item
// output  | out       | o_valid / i_stall   | o_dot_result
//
// the four lane products are formed in parallel and registered, then added into the fp32
// accumulator one per cycle by a single adder unless a closing add waits for r_fin
// a new item is accepted while the previous one is still being added
// a last item's sum goes from the adder into r_fin and then into r_out with o_valid
// i_rst_n is synchronous, active low; it clears the accumulator to +0
// a stalled output holds; one finished sum may wait behind it before input stalls
module ternary_weight_fp16_dot_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_code_byte,
    input  logic [15:0] i_act_lane0,
    input  logic [15:0] i_act_lane1,
    input  logic [15:0] i_act_lane2,
    input  logic [15:0] i_act_lane3,
    input  logic [15:0] i_block_scale,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_dot_result
);
    import twfd_pkg::*;

    // lane inputs and products
    logic [15:0] w_act  [LANES];
    logic [31:0] w_prod [LANES];

    // product bank, waits here while the adder walks the lanes
    logic [31:0]       r_prod [LANES];
    logic              r_pv;
    logic              r_plast;
    logic [LANE_W-1:0] r_lane;

    // accumulator and finished sum
    logic [31:0] r_acc;
    logic [31:0] r_fin;
    logic        r_fv;

    // output register
    logic        r_ov;
    logic [15:0] r_out;

    logic [31:0] w_sum;
    logic        lane_end;
    logic        fin_drain;
    logic        step;
    logic        close;
    logic        take_in;

    assign w_act[0] = i_act_lane0;
    assign w_act[1] = i_act_lane1;
    assign w_act[2] = i_act_lane2;
    assign w_act[3] = i_act_lane3;

    for (genvar p = 0; p < LANES; p++) begin : g_lane
        twfd_lane u_lane (
            .i_code  (i_code_byte[2*p +: 2]),
            .i_act   (w_act[p]),
            .i_scale (i_block_scale),
            .o_prod  (w_prod[p])
        );
    end

    // merge: lane products added in lane order
    twfd_fadd u_fadd (
        .i_a   (r_acc),
        .i_b   (r_prod[r_lane]),
        .o_sum (w_sum)
    );

    assign lane_end  = (r_lane == LANE_LAST);
    assign fin_drain = r_fv && (!r_ov || !i_stall);
    // closing add of a last item needs the finished-sum slot free
    assign step      = r_pv && !(lane_end && r_plast && r_fv && !fin_drain);
    assign close     = step && lane_end && r_plast;
    assign o_stall   = r_pv && !(step && lane_end);
    assign take_in   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_prod  <= w_prod;
            r_plast <= i_last_item;
        end
        if (close) begin
            r_fin <= w_sum;
        end
        if (fin_drain) begin
            r_out <= f32_to_f16(r_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_lane <= '0;
            r_acc  <= F32_PZERO;
            r_fv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            // product bank
            if (take_in) begin
                r_pv <= 1'b1;
            end else if (step && lane_end) begin
                r_pv <= 1'b0;
            end
            if (step) begin
                r_lane <= lane_end ? '0 : r_lane + 1'b1;
                r_acc  <= close ? F32_PZERO : w_sum;
            end
            // finished sum
            if (close) begin
                r_fv <= 1'b1;
            end else if (fin_drain) begin
                r_fv <= 1'b0;
            end
            // output
            if (fin_drain) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_dot_result = r_out;

endmodule

// ===== rtl/twfd_checker.sv =====
module twfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_dot_result
);
    `include "ternary_weight_fp16_dot_accumulator_assert.svh"

    // a stalled result stays
    `TWFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `TWFD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_dot_result))
    // an accepted item occupies the product bank for its lane walk
    `TWFD_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // no result can appear in the cycle right after reset
    `TWFD_ASSERT_NOW(a_rst_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

endmodule

bind ternary_weight_fp16_dot_accumulator twfd_checker u_twfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_dot_result (o_dot_result)
);
